/* rtl/servo_shutter_controller_defines.svh */
// Assertion macros shared by the servo shutter controller RTL.
`ifndef SERVO_SHUTTER_CONTROLLER_DEFINES_SVH
`define SERVO_SHUTTER_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/ssc_pkg.sv */
// Shared types and constants of the servo shutter controller.
`default_nettype none

package ssc_pkg;

    localparam int SERVO_MAX  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_DIVIDER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_UNITS = 3'd4;

    localparam logic [9:0]  RST_CLOSED_WIDTH  = 10'd21;
    localparam logic [9:0]  RST_OPEN_WIDTH    = 10'd26;
    localparam logic [9:0]  RST_FRAME_TICKS   = 10'd360;
    localparam logic [15:0] RST_UNIT_DIVIDER  = 16'd2001;
    localparam logic [7:0]  RST_TIMEOUT_UNITS = 8'd5;

    localparam logic [7:0] CHAR_S_UP = 8'h53;
    localparam logic [7:0] CHAR_S_LO = 8'h73;
    localparam logic [7:0] CHAR_Q_UP = 8'h51;
    localparam logic [7:0] CHAR_Q_LO = 8'h71;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [1:0] {
        REPLY_CLOSED    = 2'd0,
        REPLY_OPEN      = 2'd1,
        REPLY_BAD_SERVO = 2'd2,
        REPLY_TIMEOUT   = 2'd3
    } t_reply;

    typedef struct packed {
        logic [9:0]  closed_width;
        logic [9:0]  open_width;
        logic [9:0]  frame_ticks;
        logic [15:0] unit_divider;
        logic [7:0]  timeout_units;
    } t_cfg;

    typedef struct packed {
        logic                 reply_valid;
        t_reply               reply_code;
        logic                 set_en;
        logic                 set_open;
        logic [SERVO_MAX-1:0] mask;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/ssc_cfg_regs.sv */
// Configuration register bank of the servo shutter controller.
`default_nettype none

module ssc_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output      ssc_pkg::t_cfg                  o_cfg
);
    import ssc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.closed_width  <= RST_CLOSED_WIDTH;
            r_cfg.open_width    <= RST_OPEN_WIDTH;
            r_cfg.frame_ticks   <= RST_FRAME_TICKS;
            r_cfg.unit_divider  <= RST_UNIT_DIVIDER;
            r_cfg.timeout_units <= RST_TIMEOUT_UNITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLOSED_WIDTH:  r_cfg.closed_width  <= i_cfg_data[9:0];
                CFG_OPEN_WIDTH:    r_cfg.open_width    <= i_cfg_data[9:0];
                CFG_FRAME_TICKS:   r_cfg.frame_ticks   <= i_cfg_data[9:0];
                CFG_UNIT_DIVIDER:  r_cfg.unit_divider  <= i_cfg_data[15:0];
                CFG_TIMEOUT_UNITS: r_cfg.timeout_units <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/ssc_timebase.sv */
// Frame counter and coarse time-unit divider.
`default_nettype none

module ssc_timebase (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [9:0]  i_frame_ticks,
    input  wire logic [15:0] i_unit_divider,
    output      logic [9:0]  o_frame_count,
    output      logic        o_unit_adv
);
    logic [9:0]  r_frame;
    logic [9:0]  n_frame;
    logic [15:0] r_unit;
    logic [15:0] n_unit;
    logic        r_unit_adv;
    logic        n_unit_adv;
    logic [10:0] w_frame_inc;
    logic [15:0] w_unit_inc;

    always_comb begin
        w_frame_inc = {1'b0, r_frame} + 11'd1;
        n_frame     = (w_frame_inc < {1'b0, i_frame_ticks}) ? w_frame_inc[9:0] : 10'd0;
        w_unit_inc  = r_unit + 16'd1;
        n_unit_adv  = (w_unit_inc >= i_unit_divider);
        n_unit      = n_unit_adv ? 16'd0 : w_unit_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= 10'd0;
            r_unit     <= 16'd0;
            r_unit_adv <= 1'b0;
        end else if (i_step) begin
            r_frame    <= n_frame;
            r_unit     <= n_unit;
            r_unit_adv <= n_unit_adv;
        end
    end

    assign o_frame_count = r_frame;
    assign o_unit_adv    = r_unit_adv;

endmodule

`default_nettype wire

/* rtl/ssc_cmd_parser.sv */
// Serial command parser for set and query commands with timeout.
`default_nettype none

module ssc_cmd_parser #(
    parameter int SERVO_CHANS = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_step,
    input  wire logic                   i_byte_valid,
    input  wire logic [7:0]             i_rx_byte,
    input  wire logic                   i_unit_adv,
    input  wire logic [7:0]             i_timeout_units,
    input  wire logic [SERVO_CHANS-1:0] i_servo_open,
    output      ssc_pkg::t_cmd          o_cmd
);
    import ssc_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_SET_SERVO = 2'd1,
        PH_SET_STATE = 2'd2,
        PH_QUERY     = 2'd3
    } t_phase;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_held;
    logic [3:0] n_held;
    logic [7:0] r_units;
    logic [7:0] n_units;

    logic                 w_is_digit;
    logic                 w_is_eol;
    logic                 w_done;
    logic [3:0]           w_digit;
    logic [SERVO_MAX-1:0] w_cur_mask;
    logic [SERVO_MAX-1:0] w_held_mask;
    t_cmd                 w_cmd;

    always_comb begin
        w_is_digit = (i_rx_byte >= CHAR_ZERO) && (i_rx_byte <= CHAR_NINE);
        w_is_eol   = (i_rx_byte == CHAR_CR) || (i_rx_byte == CHAR_LF);
        w_done     = w_is_digit || w_is_eol;
        w_digit    = w_is_digit ? i_rx_byte[3:0] : 4'd0;
        w_cur_mask  = '0;
        w_held_mask = '0;
        for (int k = 0; k < SERVO_CHANS; k++) begin
            w_cur_mask[k]  = (w_digit == 4'(k + 1));
            w_held_mask[k] = (r_held == 4'(k + 1));
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_units = r_units;
        w_cmd   = '0;

        if (r_phase != PH_IDLE && i_unit_adv) begin
            if (r_units <= 8'd1) begin
                w_cmd.reply_valid = 1'b1;
                w_cmd.reply_code  = REPLY_TIMEOUT;
                n_phase           = PH_IDLE;
                n_units           = 8'd0;
            end else begin
                n_units = r_units - 8'd1;
            end
        end

        if (i_byte_valid) begin
            case (n_phase)
                PH_IDLE: begin
                    if (i_rx_byte == CHAR_S_UP || i_rx_byte == CHAR_S_LO) begin
                        n_phase = PH_SET_SERVO;
                        n_units = i_timeout_units;
                    end else if (i_rx_byte == CHAR_Q_UP || i_rx_byte == CHAR_Q_LO) begin
                        n_phase = PH_QUERY;
                        n_units = i_timeout_units;
                    end
                end
                PH_SET_SERVO: begin
                    if (w_is_digit) begin
                        n_held  = w_digit;
                        n_phase = PH_SET_STATE;
                    end else if (w_is_eol) begin
                        w_cmd.reply_valid = 1'b1;
                        w_cmd.reply_code  = REPLY_BAD_SERVO;
                        n_phase           = PH_IDLE;
                    end
                end
                PH_SET_STATE: begin
                    if (w_done) begin
                        if (|w_held_mask) begin
                            w_cmd.set_en   = 1'b1;
                            w_cmd.set_open = (i_rx_byte == CHAR_ONE);
                            w_cmd.mask     = w_held_mask;
                        end else begin
                            w_cmd.reply_valid = 1'b1;
                            w_cmd.reply_code  = REPLY_BAD_SERVO;
                        end
                        n_phase = PH_IDLE;
                    end
                end
                PH_QUERY: begin
                    if (w_done) begin
                        w_cmd.reply_valid = 1'b1;
                        if (|w_cur_mask) begin
                            w_cmd.reply_code = (|(i_servo_open & w_cur_mask[SERVO_CHANS-1:0]))
                                ? REPLY_OPEN : REPLY_CLOSED;
                        end else begin
                            w_cmd.reply_code = REPLY_BAD_SERVO;
                        end
                        n_phase = PH_IDLE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 4'd0;
            r_units <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_units <= n_units;
        end
    end

    assign o_cmd = w_cmd;

endmodule

`default_nettype wire

/* rtl/servo_shutter_controller.sv */
// Top level of the servo shutter controller: beat registers, servo state and PWM.
`default_nettype none

// Each input beat is one timer tick. A beat is taken into an input register and
// processed in a single pass into the result register once that register is free, so
// one beat can be accepted every clock while the result side keeps up; a waiting
// result only stalls input once the input register is also full. Configuration
// writes take effect at the next edge and are meant to be issued while no beat is
// in flight.

module servo_shutter_controller #(
    parameter int SERVO_CHANS = 4
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [SERVO_CHANS-1:0]         i_buttons,
    input  wire logic                           i_byte_valid,
    input  wire logic [7:0]                     i_rx_byte,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [SERVO_CHANS-1:0]         o_pwm,
    output      logic [SERVO_CHANS-1:0]         o_leds,
    output      logic                           o_reply_valid,
    output      logic [1:0]                     o_reply_code
);
    import ssc_pkg::*;
    `include "servo_shutter_controller_defines.svh"

    logic                   r_in_valid;
    logic [SERVO_CHANS-1:0] r_buttons;
    logic                   r_byte_valid;
    logic [7:0]             r_rx_byte;

    logic                   r_out_valid;
    logic [SERVO_CHANS-1:0] r_pwm;
    logic [SERVO_CHANS-1:0] r_leds;
    logic                   r_reply_valid;
    t_reply                 r_reply_code;

    logic                   r_primed;
    logic [SERVO_CHANS-1:0] r_last_buttons;
    logic [SERVO_CHANS-1:0] r_servo_open;
    logic [SERVO_CHANS-1:0] n_last_buttons;
    logic [SERVO_CHANS-1:0] n_servo_open;

    logic                   w_move;
    logic                   w_in_ready;
    logic [SERVO_CHANS-1:0] w_toggled;
    logic [SERVO_CHANS-1:0] w_mask;
    logic [SERVO_CHANS-1:0] n_pwm;
    logic [9:0]             w_frame_count;
    logic                   w_unit_adv;
    t_cfg                   w_cfg;
    t_cmd                   w_cmd;

    assign w_move     = r_in_valid && (!r_out_valid || i_out_ready);
    assign w_in_ready = !r_in_valid || w_move;

    ssc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ssc_timebase u_timebase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_move),
        .i_frame_ticks  (w_cfg.frame_ticks),
        .i_unit_divider (w_cfg.unit_divider),
        .o_frame_count  (w_frame_count),
        .o_unit_adv     (w_unit_adv)
    );

    ssc_cmd_parser #(
        .SERVO_CHANS (SERVO_CHANS)
    ) u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_move),
        .i_byte_valid    (r_byte_valid),
        .i_rx_byte       (r_rx_byte),
        .i_unit_adv      (w_unit_adv),
        .i_timeout_units (w_cfg.timeout_units),
        .i_servo_open    (w_toggled),
        .o_cmd           (w_cmd)
    );

    always_comb begin
        w_toggled      = r_servo_open;
        n_last_buttons = r_last_buttons;
        if (!r_primed) begin
            n_last_buttons = r_buttons;
        end else if (w_unit_adv) begin
            w_toggled      = r_servo_open ^ (r_buttons & ~r_last_buttons);
            n_last_buttons = r_buttons;
        end

        w_mask       = w_cmd.mask[SERVO_CHANS-1:0];
        n_servo_open = w_toggled;
        if (w_cmd.set_en) begin
            n_servo_open = w_cmd.set_open ? (w_toggled | w_mask) : (w_toggled & ~w_mask);
        end

        for (int k = 0; k < SERVO_CHANS; k++) begin
            n_pwm[k] = w_frame_count <= (n_servo_open[k] ? w_cfg.open_width
                                                         : w_cfg.closed_width);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_primed     <= 1'b0;
            r_servo_open <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_move) begin
                r_out_valid  <= 1'b1;
                r_primed     <= 1'b1;
                r_servo_open <= n_servo_open;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in_valid) begin
            r_buttons    <= i_buttons;
            r_byte_valid <= i_byte_valid;
            r_rx_byte    <= i_rx_byte;
        end
        if (w_move) begin
            r_last_buttons <= n_last_buttons;
            r_pwm          <= n_pwm;
            r_leds         <= n_servo_open;
            r_reply_valid  <= w_cmd.reply_valid;
            r_reply_code   <= w_cmd.reply_valid ? w_cmd.reply_code : REPLY_CLOSED;
        end
    end

    assign o_in_ready    = w_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_pwm         = r_pwm;
    assign o_leds        = r_leds;
    assign o_reply_valid = r_reply_valid;
    assign o_reply_code  = r_reply_code;

    `SSC_ASSERT_NOW(a_ready_when_out_free, i_clk, i_rst_n, !r_out_valid, w_in_ready)
    `SSC_ASSERT_NEXT(a_state_holds_on_stall, i_clk, i_rst_n, !w_move, $stable(r_servo_open))
    `SSC_ASSERT_NOW(a_code_zero_no_reply, i_clk, i_rst_n,
        r_out_valid && !r_reply_valid, r_reply_code == REPLY_CLOSED)

endmodule

`default_nettype wire

/* sim/servo_shutter_controller_tb.sv */
// Testbench for the servo shutter controller: directed table, random command streams, predictor.
`timescale 1ns / 100ps

module servo_shutter_controller_tb;
    import ssc_pkg::*;

    localparam int NSERVO = 4;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SET_SERVO,
        PH_SET_STATE,
        PH_QUERY
    } t_parse_phase;

    typedef struct packed {
        logic [3:0] buttons;
        logic       bv;
        logic [7:0] rx;
    } t_tick_in;

    typedef struct packed {
        logic [3:0] pwm;
        logic [3:0] leds;
        logic       reply_valid;
        t_reply     reply_code;
    } t_tick_result;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        t_tick_in             tick;
        logic                 chk;
        t_tick_result         res;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [NSERVO-1:0]     i_buttons = '0;
    logic                  i_byte_valid = 1'b0;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [NSERVO-1:0]     o_pwm;
    logic [NSERVO-1:0]     o_leds;
    logic                  o_reply_valid;
    logic [1:0]            o_reply_code;

    servo_shutter_controller #(.SERVO_CHANS(NSERVO)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_buttons    (i_buttons),
        .i_byte_valid (i_byte_valid),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pwm        (o_pwm),
        .o_leds       (o_leds),
        .o_reply_valid(o_reply_valid),
        .o_reply_code (o_reply_code)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the block
    logic [9:0]   cfg_closed, cfg_open, cfg_frame;
    logic [15:0]  cfg_div;
    logic [7:0]   cfg_timeout;
    int           pwm_count, tick_in_unit, units_remaining;
    logic [3:0]   open_mask, prev_buttons, servo_sel;
    logic         unit_edge, buttons_seen;
    t_parse_phase parser_phase;

    t_tick_result expected_beats[$];
    t_tick_in     pending_ticks[$];
    t_row         directed_rows[$];
    logic [3:0]   button_level = '0;
    logic         burst = 1'b0;
    int           hold_cycles = 0;
    int           errors = 0;

    function automatic t_tick_result predict_tick(t_tick_in t);
        t_tick_result r;
        logic         is_dig, is_eol;
        logic [3:0]   dig;
        r = '0;
        r.reply_code = REPLY_CLOSED;
        if (!buttons_seen) begin
            prev_buttons = t.buttons;
            buttons_seen = 1'b1;
        end else if (unit_edge) begin
            open_mask = open_mask ^ (t.buttons & ~prev_buttons);
            prev_buttons = t.buttons;
        end
        if (parser_phase != PH_IDLE && unit_edge) begin
            if (units_remaining <= 1) begin
                r.reply_valid = 1'b1;
                r.reply_code = REPLY_TIMEOUT;
                parser_phase = PH_IDLE;
                units_remaining = 0;
            end else begin
                units_remaining--;
            end
        end
        if (t.bv) begin
            is_dig = (t.rx >= CHAR_ZERO) && (t.rx <= CHAR_NINE);
            is_eol = (t.rx == CHAR_CR) || (t.rx == CHAR_LF);
            dig = is_dig ? 4'(t.rx - CHAR_ZERO) : 4'd0;
            case (parser_phase)
                PH_IDLE: begin
                    if (t.rx == CHAR_S_UP || t.rx == CHAR_S_LO) begin
                        parser_phase = PH_SET_SERVO;
                        units_remaining = cfg_timeout;
                    end else if (t.rx == CHAR_Q_UP || t.rx == CHAR_Q_LO) begin
                        parser_phase = PH_QUERY;
                        units_remaining = cfg_timeout;
                    end
                end
                PH_SET_SERVO: begin
                    if (is_dig) begin
                        servo_sel = dig;
                        parser_phase = PH_SET_STATE;
                    end else if (is_eol) begin
                        r.reply_valid = 1'b1;
                        r.reply_code = REPLY_BAD_SERVO;
                        parser_phase = PH_IDLE;
                    end
                end
                PH_SET_STATE: begin
                    if (is_dig || is_eol) begin
                        if (servo_sel >= 1 && servo_sel <= NSERVO) begin
                            open_mask[servo_sel - 1] = (t.rx == CHAR_ONE);
                        end else begin
                            r.reply_valid = 1'b1;
                            r.reply_code = REPLY_BAD_SERVO;
                        end
                        parser_phase = PH_IDLE;
                    end
                end
                default: begin
                    if (is_dig || is_eol) begin
                        r.reply_valid = 1'b1;
                        if (dig >= 1 && dig <= NSERVO) begin
                            r.reply_code = open_mask[dig - 1] ? REPLY_OPEN : REPLY_CLOSED;
                        end else begin
                            r.reply_code = REPLY_BAD_SERVO;
                        end
                        parser_phase = PH_IDLE;
                    end
                end
            endcase
        end
        for (int i = 0; i < NSERVO; i++) begin
            r.pwm[i] = pwm_count <= (open_mask[i] ? cfg_open : cfg_closed);
        end
        pwm_count = (pwm_count + 1 < cfg_frame) ? pwm_count + 1 : 0;
        tick_in_unit++;
        if (tick_in_unit >= cfg_div) begin
            tick_in_unit = 0;
            unit_edge = 1'b1;
        end else begin
            unit_edge = 1'b0;
        end
        r.leds = open_mask;
        return r;
    endfunction

    task automatic report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("mismatch %0d at %0t: %s", errors, $realtime, msg);
        end
    endtask

    task automatic send_tick(t_tick_in t, logic chk, t_tick_result typed);
        int           gap;
        t_tick_result r;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_buttons    <= t.buttons;
        i_byte_valid <= t.bv;
        i_rx_byte    <= t.rx;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = predict_tick(t);
        expected_beats.push_back(chk ? typed : r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_CLOSED_WIDTH:  cfg_closed = val[9:0];
            CFG_OPEN_WIDTH:    cfg_open = val[9:0];
            CFG_FRAME_TICKS:   cfg_frame = val[9:0];
            CFG_UNIT_DIVIDER:  cfg_div = val;
            CFG_TIMEOUT_UNITS: cfg_timeout = val[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [15:0] closed_w, logic [15:0] open_w, logic [15:0] frame,
                             logic [15:0] div, logic [15:0] tmo);
        drain();
        cfg_write(CFG_CLOSED_WIDTH, closed_w);
        cfg_write(CFG_OPEN_WIDTH, open_w);
        cfg_write(CFG_FRAME_TICKS, frame);
        cfg_write(CFG_UNIT_DIVIDER, div);
        cfg_write(CFG_TIMEOUT_UNITS, tmo);
    endtask

    task automatic row(logic [3:0] b, logic v, logic [7:0] x, logic chk, logic [3:0] pwm,
                       logic [3:0] leds, logic rv, t_reply code);
        t_row r;
        r = '0;
        r.tick = '{buttons: b, bv: v, rx: x};
        r.chk = chk;
        r.res = '{pwm: pwm, leds: leds, reply_valid: rv, reply_code: code};
        directed_rows.push_back(r);
    endtask

    task automatic row_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        directed_rows.push_back(r);
    endtask

    task automatic queue_tick(logic v, logic [7:0] x);
        t_tick_in t;
        if ($urandom_range(0, 7) == 0) begin
            button_level[$urandom_range(0, NSERVO - 1)] ^= 1'b1;
        end
        t.buttons = button_level;
        t.bv = v;
        t.rx = x;
        pending_ticks.push_back(t);
    endtask

    task automatic queue_byte(logic [7:0] x);
        int n;
        n = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) n = $urandom_range(4, 20);
        repeat (n) queue_tick(1'b0, 8'($urandom));
        queue_tick(1'b1, x);
    endtask

    function automatic logic [7:0] servo_digit();
        if ($urandom_range(0, 5) == 0) return CHAR_ZERO + 8'($urandom_range(0, 9));
        return CHAR_ZERO + 8'($urandom_range(1, NSERVO));
    endfunction

    function automatic logic [7:0] line_end();
        return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
    endfunction

    // non-digit, non-line-end filler that a running command skips
    function automatic logic [7:0] filler();
        return 8'($urandom_range(8'h3A, 8'hFF));
    endfunction

    task automatic queue_command();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            queue_byte($urandom_range(0, 1) ? CHAR_S_UP : CHAR_S_LO);
            if ($urandom_range(0, 5) == 0) queue_byte(filler());
            queue_byte(servo_digit());
            if ($urandom_range(0, 5) == 0) queue_byte(filler());
            case ($urandom_range(0, 4))
                0:       queue_byte(line_end());
                1, 2:    queue_byte(CHAR_ONE);
                3:       queue_byte(CHAR_ZERO);
                default: queue_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
            endcase
        end else if (kind <= 6) begin
            queue_byte($urandom_range(0, 1) ? CHAR_Q_UP : CHAR_Q_LO);
            if ($urandom_range(0, 5) == 0) queue_byte(filler());
            if ($urandom_range(0, 5) == 0) queue_byte(line_end());
            else queue_byte(servo_digit());
        end else if (kind == 7) begin
            queue_byte($urandom_range(0, 1) ? CHAR_S_UP : CHAR_S_LO);
            queue_byte(line_end());
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 3)) queue_byte(8'($urandom));
        end else begin
            queue_byte($urandom_range(0, 1) ? CHAR_Q_UP : CHAR_S_LO);
            repeat ($urandom_range(5, 40)) queue_tick(1'b0, 8'($urandom));
        end
    endtask

    initial begin : result_monitor
        int           stall;
        t_tick_result want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = burst ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (expected_beats.size() == 0) begin
                report("result beat with nothing expected");
            end else begin
                want = expected_beats.pop_front();
                if (o_pwm !== want.pwm)
                    report($sformatf("pwm got %h want %h", o_pwm, want.pwm));
                if (o_leds !== want.leds)
                    report($sformatf("leds got %h want %h", o_leds, want.leds));
                if (o_reply_valid !== want.reply_valid)
                    report($sformatf("reply_valid got %b want %b", o_reply_valid,
                                     want.reply_valid));
                if (o_reply_code !== want.reply_code)
                    report($sformatf("reply_code got %0d want %0d", o_reply_code,
                                     want.reply_code));
            end
        end
    end

    initial begin : run_limit
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int       sent;
        t_tick_in t;
        cfg_closed = RST_CLOSED_WIDTH;
        cfg_open = RST_OPEN_WIDTH;
        cfg_frame = RST_FRAME_TICKS;
        cfg_div = RST_UNIT_DIVIDER;
        cfg_timeout = RST_TIMEOUT_UNITS;
        pwm_count = 0;
        tick_in_unit = 0;
        units_remaining = 0;
        open_mask = '0;
        prev_buttons = '0;
        servo_sel = '0;
        unit_edge = 1'b0;
        buttons_seen = 1'b0;
        parser_phase = PH_IDLE;

        row(4'h0, 1'b0, 8'h00,     1'b1, 4'hF, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hF, 1'b1, CHAR_Q_UP, 1'b1, 4'hF, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hF, 1'b1, 8'h35,     1'b1, 4'hF, 4'h0, 1'b1, REPLY_BAD_SERVO);
        row(4'h0, 1'b1, CHAR_S_UP, 1'b1, 4'hF, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, CHAR_ZERO, 1'b1, 4'hF, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h5, 1'b1, CHAR_ONE,  1'b1, 4'hF, 4'h0, 1'b1, REPLY_BAD_SERVO);
        row(4'hA, 1'b1, CHAR_S_UP, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hA, 1'b1, CHAR_CR,   1'b1, 4'hF, 4'h0, 1'b1, REPLY_BAD_SERVO);
        row(4'h0, 1'b1, CHAR_S_LO, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, 8'h34,     1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, CHAR_ONE,  1'b1, 4'hF, 4'h8, 1'b0, REPLY_CLOSED);
        row(4'h3, 1'b1, CHAR_Q_LO, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h3, 1'b1, 8'h34,     1'b1, 4'hF, 4'h8, 1'b1, REPLY_OPEN);
        row(4'hC, 1'b1, CHAR_Q_UP, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hC, 1'b1, 8'h78,     1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hC, 1'b1, CHAR_LF,   1'b1, 4'hF, 4'h8, 1'b1, REPLY_BAD_SERVO);
        row(4'h0, 1'b1, CHAR_S_UP, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, 8'h34,     1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, CHAR_NINE, 1'b1, 4'hF, 4'h0, 1'b0, REPLY_CLOSED);
        row_cfg(CFG_UNIT_DIVIDER, 16'd1);
        row_cfg(CFG_TIMEOUT_UNITS, 16'd0);
        row(4'h0, 1'b1, CHAR_Q_UP, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b1, CHAR_S_UP, 1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'h0, 1'b0, 8'hA5,     1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);
        row(4'hF, 1'b0, 8'h5A,     1'b0, 4'h0, 4'h0, 1'b0, REPLY_CLOSED);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                drain();
                cfg_write(directed_rows[k].idx, directed_rows[k].val);
            end else begin
                send_tick(directed_rows[k].tick, directed_rows[k].chk, directed_rows[k].res);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_cfg(16'd0, 16'd1023, 16'd1023, 16'd1, 16'd1);
                1: apply_cfg(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                             16'($urandom_range(2, 40)), 16'($urandom_range(1, 6)),
                             16'($urandom_range(2, 8)));
                2: apply_cfg(16'd1023, 16'd0, 16'd0, 16'd0, 16'd0);
                3: apply_cfg(16'd1023, 16'd0, 16'd2, 16'd65535, 16'd255);
                4: apply_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
                default: apply_cfg(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                                   16'd1, 16'($urandom_range(1, 3)),
                                   16'($urandom_range(1, 4)));
            endcase
            sent = 0;
            while (sent < 120 || pending_ticks.size() != 0) begin
                if (pending_ticks.size() == 0) begin
                    burst = ($urandom_range(0, 5) == 0);
                    queue_command();
                end
                if (ph == 1 && sent == 20) hold_cycles = 120;
                t = pending_ticks.pop_front();
                send_tick(t, 1'b0, '0);
                sent++;
            end
        end

        burst = 1'b0;
        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
